>>> rtl/i2cbb_pkg.sv
// Shared types, codes and step helpers for the I2C bit-bang master sequencer.
`default_nettype none

package i2cbb_pkg;

    // Command codes as they arrive on func and as held while a sequence runs.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam int STEP_W = 5;

    // Last step index of each sequence.
    localparam logic [STEP_W-1:0] START_LAST = 5'd4;
    localparam logic [STEP_W-1:0] STOP_LAST  = 5'd3;
    localparam logic [STEP_W-1:0] WRITE_LAST = 5'd26;
    localparam logic [STEP_W-1:0] READ_LAST  = 5'd20;

    // Data-bit steps of a write: three steps per bit, eight bits.
    localparam logic [STEP_W-1:0] WRITE_BIT_STEPS = 5'd24;
    localparam logic [STEP_W-1:0] WRITE_ACK_SDA   = 5'd24;
    localparam logic [STEP_W-1:0] WRITE_ACK_REL   = 5'd25;
    localparam logic [STEP_W-1:0] WRITE_ACK_LOW   = 5'd26;

    // Read steps that follow the sda release and the data-bit clock steps.
    localparam logic [STEP_W-1:0] READ_BIT_LAST = 5'd16;
    localparam logic [STEP_W-1:0] READ_ACK_SDA  = 5'd17;
    localparam logic [STEP_W-1:0] READ_ACK_REL  = 5'd18;
    localparam logic [STEP_W-1:0] READ_ACK_LOW  = 5'd19;
    localparam logic [STEP_W-1:0] READ_SDA_REL  = 5'd20;

    // Map a raw func code to a command; undefined codes mean no command.
    function automatic cmd_t decode_func(input logic [2:0] func);
        cmd_t c;
        case (func)
            CMD_START: c = CMD_START;
            CMD_STOP:  c = CMD_STOP;
            CMD_WRITE: c = CMD_WRITE;
            CMD_READ:  c = CMD_READ;
            default:   c = CMD_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [STEP_W-1:0] last_step(input cmd_t c);
        logic [STEP_W-1:0] l;
        case (c)
            CMD_START: l = START_LAST;
            CMD_STOP:  l = STOP_LAST;
            CMD_WRITE: l = WRITE_LAST;
            CMD_READ:  l = READ_LAST;
            default:   l = '0;
        endcase
        return l;
    endfunction

    // Step index modulo three through a reciprocal multiply (exact for every 5-bit index).
    function automatic logic [1:0] mod3_step(input logic [STEP_W-1:0] v);
        logic [8:0] prod;
        logic [3:0] q;
        logic [STEP_W-1:0] r;
        prod = 9'(v) * 9'd11;
        q    = prod[8:5];
        r    = v - STEP_W'(6'(q) * 6'd3);
        return r[1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2c_bitbang_master_sequencer_core.sv
// Top level of the I2C bit-bang master sequencer: tick register, step engine, result register.
`default_nettype none

// I2C master pin sequencer. Each input beat is one tick of bus time and yields exactly one
// output beat carrying the open-drain drives (scl_low, sda_low: 1 pulls the line low), the
// busy flag after that tick, and the received byte with rx_valid on the tick a read ends.
// A command on func (1 start, 2 stop, 3 write byte, 4 read byte) is taken only while idle;
// anything given while busy is dropped. Each pin-change step is held for phase_ticks ticks
// (0 counts as 1, longer holds saturate at 2**PHASE_WIDTH). After the final step one extra
// tick ends the sequence with the pins unchanged and busy low. The slave acknowledge of a
// write is clocked but not sampled; there is no clock stretching. Throughput is one beat per
// clock while neither side stalls: a beat passes through an input register, one pass of step
// logic that updates the sequencer state, and a result register, and out_valid rises once
// the beat is loaded into the result register. Both sides stall independently; in_ready
// stays high while the result register is free or being drained. phase_ticks is written
// through cfg_we/cfg_wdata; the user must do so only while idle, the block does not enforce it.
module i2c_bitbang_master_sequencer_core #(
    parameter int PHASE_WIDTH = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    // input tick channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] func,
    input  wire logic [7:0] tx_data,
    input  wire logic       ack_wanted,
    input  wire logic       sda_in,
    // result channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_low,
    output logic            sda_low,
    output logic            busy_res,
    output logic [7:0]      rx_data,
    output logic            rx_valid
);

    localparam int STEP_W = i2cbb_pkg::STEP_W;
    // Width wide enough to compare an 8-bit hold against the counter limit.
    localparam int HOLD_W = (PHASE_WIDTH > 8) ? PHASE_WIDTH : 8;

    // ---------------------------------------------------------------- configuration
    logic [7:0] phase_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- handshake
    logic       s1_valid_reg;
    logic       out_valid_reg;
    logic       s2_free;
    logic       adv;

    // Result register can take a beat when empty or being drained this cycle.
    assign s2_free  = !out_valid_reg || out_ready;
    assign adv      = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    // ---------------------------------------------------------------- input register
    logic [2:0] func_reg;
    logic [7:0] tx_data_reg;
    logic       ack_wanted_reg;
    logic       sda_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Payload needs no reset; capture only on accept.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg       <= func;
            tx_data_reg    <= tx_data;
            ack_wanted_reg <= ack_wanted;
            sda_in_reg     <= sda_in;
        end
    end

    // ---------------------------------------------------------------- sequencer state
    i2cbb_pkg::cmd_t   active_cmd_reg,  active_cmd_next;
    logic [STEP_W-1:0] step_index_reg,  step_index_next;
    logic [PHASE_WIDTH-1:0] phase_count_reg, phase_count_next;
    logic              scl_drive_reg,   scl_drive_next;
    logic              sda_drive_reg,   sda_drive_next;
    logic [7:0]        shift_byte_reg,  shift_byte_next;
    logic              ack_flag_reg,    ack_flag_next;

    // ---------------------------------------------------------------- step decode
    i2cbb_pkg::cmd_t   func_cmd;
    logic              idle;
    logic              start_cmd;
    logic              count_down;
    logic              step_go;
    logic [STEP_W-1:0] idx_inc;
    logic              step_ok;
    logic              finish;
    logic              rx_done;

    assign func_cmd   = i2cbb_pkg::decode_func(func_reg);
    assign idle       = (active_cmd_reg == i2cbb_pkg::CMD_NONE);
    assign start_cmd  = idle && (func_cmd != i2cbb_pkg::CMD_NONE);
    assign count_down = !idle && (phase_count_reg != '0);
    assign step_go    = !idle && (phase_count_reg == '0);
    assign idx_inc    = step_index_reg + STEP_W'(1);
    assign step_ok    = (idx_inc <= i2cbb_pkg::last_step(active_cmd_reg));
    // One tick past the last held step ends the sequence.
    assign finish     = step_go && !step_ok;
    assign rx_done    = finish && (active_cmd_reg == i2cbb_pkg::CMD_READ);

    // Hold reload: zero counts as one, then saturate at the counter limit.
    logic [7:0]             hold_m1;
    logic [HOLD_W-1:0]      hold_ext;
    logic [HOLD_W-1:0]      hold_max_ext;
    logic [PHASE_WIDTH-1:0] hold_load;

    assign hold_m1      = (phase_ticks_reg == 8'd0) ? 8'd0 : phase_ticks_reg - 8'd1;
    assign hold_ext     = HOLD_W'(hold_m1);
    assign hold_max_ext = HOLD_W'({PHASE_WIDTH{1'b1}});
    assign hold_load    = (hold_ext > hold_max_ext) ? {PHASE_WIDTH{1'b1}}
                                                    : hold_ext[PHASE_WIDTH-1:0];

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        active_cmd_next = active_cmd_reg;
        if (start_cmd)
        begin
            active_cmd_next = func_cmd;
        end
        else if (finish)
        begin
            active_cmd_next = i2cbb_pkg::CMD_NONE;
        end
    end

    // ---------------------------------------------------------------- step outputs
    i2cbb_pkg::cmd_t   apply_cmd;
    logic [STEP_W-1:0] apply_idx;
    logic              apply_en;
    logic [7:0]        shift_base;
    logic [1:0]        bit_phase;

    assign apply_cmd = start_cmd ? func_cmd : active_cmd_reg;
    assign apply_idx = start_cmd ? '0 : idx_inc;
    assign apply_en  = start_cmd || (step_go && step_ok);
    assign bit_phase = i2cbb_pkg::mod3_step(apply_idx);

    always_comb
    begin
        // Load the shift register for the new command before its first step.
        shift_base = shift_byte_reg;
        if (start_cmd && (func_cmd == i2cbb_pkg::CMD_WRITE))
        begin
            shift_base = tx_data_reg;
        end
        else if (start_cmd && (func_cmd == i2cbb_pkg::CMD_READ))
        begin
            shift_base = 8'd0;
        end

        ack_flag_next = ack_flag_reg;
        if (start_cmd && (func_cmd == i2cbb_pkg::CMD_READ))
        begin
            ack_flag_next = ack_wanted_reg;
        end

        scl_drive_next  = scl_drive_reg;
        sda_drive_next  = sda_drive_reg;
        shift_byte_next = shift_base;

        if (apply_en)
        begin
            case (apply_cmd)
                i2cbb_pkg::CMD_START:
                begin
                    case (apply_idx)
                        5'd0:    scl_drive_next = 1'b1;
                        5'd1:    sda_drive_next = 1'b0;
                        5'd2:    scl_drive_next = 1'b0;
                        5'd3:    sda_drive_next = 1'b1;
                        5'd4:    scl_drive_next = 1'b1;
                        default: scl_drive_next = scl_drive_reg;
                    endcase
                end
                i2cbb_pkg::CMD_STOP:
                begin
                    case (apply_idx)
                        5'd0:    scl_drive_next = 1'b1;
                        5'd1:    sda_drive_next = 1'b1;
                        5'd2:    scl_drive_next = 1'b0;
                        5'd3:    sda_drive_next = 1'b0;
                        default: scl_drive_next = scl_drive_reg;
                    endcase
                end
                i2cbb_pkg::CMD_WRITE:
                begin
                    if (apply_idx < i2cbb_pkg::WRITE_BIT_STEPS)
                    begin
                        case (bit_phase)
                            2'd0:    sda_drive_next = ~shift_base[7];
                            2'd1:    scl_drive_next = 1'b0;
                            default:
                            begin
                                scl_drive_next  = 1'b1;
                                shift_byte_next = {shift_base[6:0], 1'b0};
                            end
                        endcase
                    end
                    else if (apply_idx == i2cbb_pkg::WRITE_ACK_SDA)
                    begin
                        sda_drive_next = 1'b0;
                    end
                    else if (apply_idx == i2cbb_pkg::WRITE_ACK_REL)
                    begin
                        scl_drive_next = 1'b0;
                    end
                    else if (apply_idx == i2cbb_pkg::WRITE_ACK_LOW)
                    begin
                        scl_drive_next = 1'b1;
                    end
                end
                i2cbb_pkg::CMD_READ:
                begin
                    if (apply_idx == '0)
                    begin
                        sda_drive_next = 1'b0;
                    end
                    else if (apply_idx <= i2cbb_pkg::READ_BIT_LAST)
                    begin
                        if (apply_idx[0])
                        begin
                            scl_drive_next = 1'b0;
                        end
                        else
                        begin
                            // Sample at the end of the high phase as scl is pulled low.
                            shift_byte_next = {shift_base[6:0], sda_in_reg};
                            scl_drive_next  = 1'b1;
                        end
                    end
                    else if (apply_idx == i2cbb_pkg::READ_ACK_SDA)
                    begin
                        sda_drive_next = ack_flag_next;
                    end
                    else if (apply_idx == i2cbb_pkg::READ_ACK_REL)
                    begin
                        scl_drive_next = 1'b0;
                    end
                    else if (apply_idx == i2cbb_pkg::READ_ACK_LOW)
                    begin
                        scl_drive_next = 1'b1;
                    end
                    else if (apply_idx == i2cbb_pkg::READ_SDA_REL)
                    begin
                        sda_drive_next = 1'b0;
                    end
                end
                default:
                begin
                    scl_drive_next = scl_drive_reg;
                end
            endcase
        end

        if (apply_en)
        begin
            phase_count_next = hold_load;
        end
        else if (count_down)
        begin
            phase_count_next = phase_count_reg - PHASE_WIDTH'(1);
        end
        else
        begin
            phase_count_next = phase_count_reg;
        end

        if (start_cmd)
        begin
            step_index_next = '0;
        end
        else if (step_go)
        begin
            step_index_next = step_ok ? idx_inc : '0;
        end
        else
        begin
            step_index_next = step_index_reg;
        end
    end

    // Advance the sequencer once per tick that moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cmd_reg  <= i2cbb_pkg::CMD_NONE;
            step_index_reg  <= '0;
            phase_count_reg <= '0;
            scl_drive_reg   <= 1'b0;
            sda_drive_reg   <= 1'b0;
            shift_byte_reg  <= 8'd0;
            ack_flag_reg    <= 1'b0;
        end
        else if (adv)
        begin
            active_cmd_reg  <= active_cmd_next;
            step_index_reg  <= step_index_next;
            phase_count_reg <= phase_count_next;
            scl_drive_reg   <= scl_drive_next;
            sda_drive_reg   <= sda_drive_next;
            shift_byte_reg  <= shift_byte_next;
            ack_flag_reg    <= ack_flag_next;
        end
    end

    // ---------------------------------------------------------------- result register
    logic       scl_low_reg;
    logic       sda_low_reg;
    logic       busy_reg;
    logic [7:0] rx_data_reg;
    logic       rx_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scl_low_reg  <= scl_drive_next;
            sda_low_reg  <= sda_drive_next;
            busy_reg     <= (active_cmd_next != i2cbb_pkg::CMD_NONE);
            rx_data_reg  <= rx_done ? shift_byte_next : 8'd0;
            rx_valid_reg <= rx_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_low   = scl_low_reg;
    assign sda_low   = sda_low_reg;
    assign busy_res  = busy_reg;
    assign rx_data   = rx_data_reg;
    assign rx_valid  = rx_valid_reg;

    // ---------------------------------------------------------------- assertions
    // A finished read always reports the bus as free.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rx_valid_reg |-> !busy_reg)
        else $error("rx_valid with busy set");

    // Received data is zero except on the beat that ends a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rx_data_reg != 8'd0) |-> rx_valid_reg)
        else $error("rx_data nonzero without rx_valid");

    // The step index rests at zero while no sequence runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_cmd_reg == i2cbb_pkg::CMD_NONE) |-> (step_index_reg == '0))
        else $error("step index not cleared when idle");

    // No sequence goes past the longest step list.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_index_reg <= i2cbb_pkg::WRITE_LAST)
        else $error("step index out of range");

    // Input side stays open whenever the result register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

>>> bench/i2c_bitbang_master_sequencer_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the I2C bit-bang master sequencer core, with a tick-accurate pin predictor.

module i2c_bitbang_master_sequencer_core_test;

    // Quiet cycles (no beat on either channel) tolerated before the run is declared hung.
    // The worst legal quiet stretch is the long receiver hold-off plus a sender gap,
    // both far below this.
    localparam int WATCHDOG_LIMIT = 4000;
    // The core holds an input register and a result register; settle before touching the config register.
    localparam int DRAIN_SETTLE   = 6;
    // Length of the forced receiver stall used to fill the core and back up the input.
    localparam int LONG_HOLD_OFF  = 120;

    // func codes above the last command decode to nothing.
    localparam logic [2:0] FUNC_UNDEF_LO = 3'd5;
    localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;

    // How the sampled SDA level behaves while a directed command runs.
    typedef enum int { LINE_LOW, LINE_HIGH, LINE_RANDOM } line_mode_t;

    // One result beat as the core presents it.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic [7:0] rx;
        logic       rxv;
    } pin_beat_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [7:0] cfg_wdata  = 8'd0;
    logic       in_valid   = 1'b0;
    logic [2:0] func       = 3'd0;
    logic [7:0] tx_data    = 8'd0;
    logic       ack_wanted = 1'b0;
    logic       sda_in     = 1'b0;
    logic       out_ready  = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic [7:0] rx_data;
    logic       rx_valid;

    i2c_bitbang_master_sequencer_core #(
        .PHASE_WIDTH(8)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .tx_data   (tx_data),
        .ack_wanted(ack_wanted),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .scl_low   (scl_low),
        .sda_low   (sda_low),
        .busy_res  (busy_res),
        .rx_data   (rx_data),
        .rx_valid  (rx_valid)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    pin_beat_t expected_pins_q[$];   // predicted beats, oldest first
    int        mismatches     = 0;
    int        beats_seen     = 0;
    int        ticks_sent     = 0;
    int        bytes_read     = 0;
    int        cmd_starts[8];
    int        send_idle_pct  = 0;   // chance per beat that the sender inserts an idle cycle
    int        recv_idle_pct  = 0;   // chance per cycle that the receiver drops ready
    int        hold_off_reqs  = 0;   // bumped by a test to ask for a long receiver stall
    int        hold_off_seen  = 0;
    int        hold_off_left  = 0;
    int        quiet_cycles   = 0;

    // ------------------------------------------------------------------
    // Pin predictor: own copy of the hold setting and the sequencer state.
    // ------------------------------------------------------------------
    logic [7:0]      hold_cfg;
    logic            scl_pull;
    logic            sda_pull;
    i2cbb_pkg::cmd_t run_cmd;
    logic [4:0]      step_no;
    logic [7:0]      hold_left;
    logic [7:0]      shift_q;
    logic            ack_hold;

    function automatic void reset_model();
        hold_cfg  = 8'd1;
        scl_pull  = 1'b0;
        sda_pull  = 1'b0;
        run_cmd   = i2cbb_pkg::CMD_NONE;
        step_no   = '0;
        hold_left = '0;
        shift_q   = '0;
        ack_hold  = 1'b0;
        foreach (cmd_starts[k])
            cmd_starts[k] = 0;
    endfunction

    // Ticks left after the one that applies a step. A zero setting counts as one;
    // the longest hold (255) still fits an 8-bit counter, so no saturation shows here.
    function automatic logic [7:0] hold_reload();
        return (hold_cfg == 8'd0) ? 8'd0 : hold_cfg - 8'd1;
    endfunction

    // Apply one pin-change step; return 0 when the sequence has no step at idx.
    function automatic bit pin_step(input i2cbb_pkg::cmd_t c, input logic [4:0] idx,
                                    input logic lvl);
        bit ok;
        ok = 1'b1;
        case (c)
            i2cbb_pkg::CMD_START:
                case (idx)
                    5'd0:    scl_pull = 1'b1;
                    5'd1:    sda_pull = 1'b0;
                    5'd2:    scl_pull = 1'b0;
                    5'd3:    sda_pull = 1'b1;
                    5'd4:    scl_pull = 1'b1;
                    default: ok = 1'b0;
                endcase
            i2cbb_pkg::CMD_STOP:
                case (idx)
                    5'd0:    scl_pull = 1'b1;
                    5'd1:    sda_pull = 1'b1;
                    5'd2:    scl_pull = 1'b0;
                    5'd3:    sda_pull = 1'b0;
                    default: ok = 1'b0;
                endcase
            i2cbb_pkg::CMD_WRITE:
                if (idx < i2cbb_pkg::WRITE_BIT_STEPS)
                begin
                    // three steps per bit: set data, release clock, pull clock and shift
                    case (idx % 3)
                        0:       sda_pull = ~shift_q[7];
                        1:       scl_pull = 1'b0;
                        default:
                        begin
                            scl_pull = 1'b1;
                            shift_q  = shift_q << 1;
                        end
                    endcase
                end
                else if (idx == i2cbb_pkg::WRITE_ACK_SDA)
                    sda_pull = 1'b0;
                else if (idx == i2cbb_pkg::WRITE_ACK_REL)
                    scl_pull = 1'b0;
                else if (idx == i2cbb_pkg::WRITE_ACK_LOW)
                    scl_pull = 1'b1;
                else
                    ok = 1'b0;
            i2cbb_pkg::CMD_READ:
                if (idx == 5'd0)
                    sda_pull = 1'b0;
                else if (idx <= i2cbb_pkg::READ_BIT_LAST)
                begin
                    // odd steps release the clock, even steps sample and pull it low
                    if (idx[0])
                        scl_pull = 1'b0;
                    else
                    begin
                        shift_q  = {shift_q[6:0], lvl};
                        scl_pull = 1'b1;
                    end
                end
                else if (idx == i2cbb_pkg::READ_ACK_SDA)
                    sda_pull = ack_hold;
                else if (idx == i2cbb_pkg::READ_ACK_REL)
                    scl_pull = 1'b0;
                else if (idx == i2cbb_pkg::READ_ACK_LOW)
                    scl_pull = 1'b1;
                else if (idx == i2cbb_pkg::READ_SDA_REL)
                    sda_pull = 1'b0;
                else
                    ok = 1'b0;
            default:
                ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Advance the predictor by one accepted tick and return the beat it should produce.
    function automatic pin_beat_t advance_bus_tick(input logic [2:0] f, input logic [7:0] tx,
                                                   input logic ackw, input logic lvl);
        pin_beat_t r;
        logic      read_done;
        read_done = 1'b0;
        if (run_cmd == i2cbb_pkg::CMD_NONE)
        begin
            // idle: a defined command launches and applies its first step at once
            if (f >= i2cbb_pkg::CMD_START && f <= i2cbb_pkg::CMD_READ)
            begin
                run_cmd = i2cbb_pkg::cmd_t'(f);
                step_no = '0;
                cmd_starts[f]++;
                if (run_cmd == i2cbb_pkg::CMD_WRITE)
                    shift_q = tx;
                if (run_cmd == i2cbb_pkg::CMD_READ)
                begin
                    shift_q  = '0;
                    ack_hold = ackw;
                end
                void'(pin_step(run_cmd, step_no, lvl));
                hold_left = hold_reload();
            end
        end
        else if (hold_left != 8'd0)
            hold_left--;
        else
        begin
            step_no++;
            if (pin_step(run_cmd, step_no, lvl))
                hold_left = hold_reload();
            else
            begin
                // the tick after the last step ends the sequence, pins unchanged
                read_done = (run_cmd == i2cbb_pkg::CMD_READ);
                run_cmd   = i2cbb_pkg::CMD_NONE;
                step_no   = '0;
            end
        end
        if (read_done)
            bytes_read++;
        r.scl  = scl_pull;
        r.sda  = sda_pull;
        r.busy = (run_cmd != i2cbb_pkg::CMD_NONE);
        r.rx   = read_done ? shift_q : 8'h00;
        r.rxv  = read_done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready, plus a long counted stall on request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_seen != hold_off_reqs)
        begin
            hold_off_seen <= hold_off_reqs;
            hold_off_left <= LONG_HOLD_OFF;
            out_ready     <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            out_ready     <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Result checking: compare each beat taken against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("beat %0d: %s read %0h, want %0h", beats_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        pin_beat_t want;
        if (out_valid === 1'b1 && out_ready)
        begin
            beats_seen++;
            if (expected_pins_q.size() == 0)
                report_mismatch("beat with nothing pending", 8'd0, 8'd0);
            else
            begin
                want = expected_pins_q.pop_front();
                check_field("scl_low", 8'(scl_low), 8'(want.scl));
                check_field("sda_low", 8'(sda_low), 8'(want.sda));
                check_field("busy_res", 8'(busy_res), 8'(want.busy));
                check_field("rx_data", rx_data, want.rx);
                check_field("rx_valid", 8'(rx_valid), 8'(want.rxv));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one tick, holding valid and payload until it is taken, then predict it.
    // Always entered and left right after a rising edge.
    task automatic send_tick(input logic [2:0] f, input logic [7:0] tx, input logic ackw,
                             input logic lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        tx_data    <= tx;
        ack_wanted <= ackw;
        sda_in     <= lvl;
        do
            @(posedge clk);
        while (!in_ready);
        expected_pins_q.push_back(advance_bus_tick(f, tx, ackw, lvl));
        ticks_sent++;
    endtask

    // Mostly real commands, some plain ticks and some undefined codes; all fields random.
    task automatic send_random_tick();
        int         pick;
        logic [2:0] f;
        pick = $urandom_range(99);
        if (pick < 70)
            f = 3'($urandom_range(i2cbb_pkg::CMD_READ, i2cbb_pkg::CMD_START));
        else if (pick < 85)
            f = i2cbb_pkg::CMD_NONE;
        else
            f = 3'($urandom_range(FUNC_UNDEF_HI, FUNC_UNDEF_LO));
        send_tick(f, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Launch one command and keep ticking until the predictor reports it finished.
    // Filler ticks carry random func codes, which the busy core must ignore.
    task automatic run_command(input i2cbb_pkg::cmd_t c, input logic [7:0] tx,
                               input logic ackw, input line_mode_t m);
        logic lvl;
        lvl = (m == LINE_RANDOM) ? 1'($urandom) : (m == LINE_HIGH);
        send_tick(c, tx, ackw, lvl);
        while (run_cmd != i2cbb_pkg::CMD_NONE)
        begin
            lvl = (m == LINE_RANDOM) ? 1'($urandom) : (m == LINE_HIGH);
            send_tick(3'($urandom_range(FUNC_UNDEF_HI, i2cbb_pkg::CMD_NONE)), 8'($urandom),
                      1'($urandom), lvl);
        end
    endtask

    // Drop valid and hold until every predicted beat has come back, then settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pins_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE)
            @(posedge clk);
    endtask

    // Write the hold register with the core drained.
    task automatic write_hold_cfg(input logic [7:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hold_cfg   = v;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every command with extreme data and line levels, undefined codes while idle,
    // all under a zero hold setting (taken as one tick).
    task automatic test_directed_commands();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_hold_cfg(8'd0);
        for (int u = FUNC_UNDEF_LO; u <= FUNC_UNDEF_HI; u++)
            send_tick(3'(u), 8'hFF, 1'b1, 1'b1);
        send_tick(i2cbb_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0);
        run_command(i2cbb_pkg::CMD_START, 8'h00, 1'b0, LINE_HIGH);
        run_command(i2cbb_pkg::CMD_WRITE, 8'hFF, 1'b1, LINE_LOW);
        run_command(i2cbb_pkg::CMD_WRITE, 8'h00, 1'b0, LINE_HIGH);
        run_command(i2cbb_pkg::CMD_READ, 8'h00, 1'b1, LINE_HIGH);
        run_command(i2cbb_pkg::CMD_READ, 8'hFF, 1'b0, LINE_LOW);
        run_command(i2cbb_pkg::CMD_STOP, 8'h5A, 1'b1, LINE_RANDOM);
    endtask

    // Long hold: each step of a STOP sits for 80 ticks.
    task automatic test_long_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_hold_cfg(8'd80);
        run_command(i2cbb_pkg::CMD_STOP, 8'h81, 1'b0, LINE_RANDOM);
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input logic [7:0] hold, input int count);
        write_hold_cfg(hold);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (count)
            send_random_tick();
    endtask

    // Stall the receiver long enough to fill the core while the sender keeps offering,
    // then pause the sender until the core has fully drained, then resume.
    task automatic test_backpressure();
        write_hold_cfg(8'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_reqs <= hold_off_reqs + 1;
        repeat (60)
            send_random_tick();
        wait_drained();
        repeat (60)
            send_random_tick();
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_model();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_long_hold();
        // skewed idling both ways, then none, each under its own hold setting
        test_random_traffic(12, 61, 8'd1, 130);
        test_random_traffic(61, 12, 8'd2, 130);
        test_random_traffic(0, 0, 8'($urandom_range(3, 1)), 130);
        test_backpressure();

        wait_drained();
        $display("%0d ticks driven: %0d start, %0d stop, %0d write, %0d read launched",
                 ticks_sent, cmd_starts[i2cbb_pkg::CMD_START],
                 cmd_starts[i2cbb_pkg::CMD_STOP], cmd_starts[i2cbb_pkg::CMD_WRITE],
                 cmd_starts[i2cbb_pkg::CMD_READ]);
        $display("%0d bytes read; hold settings 0 to 3 and 80; skewed, reversed and no idling;",
                 bytes_read);
        $display("one long receiver stall with the input backed up");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
